// ===== rtl/tmsh_pkg.sv =====
package tmsh_pkg;

	localparam int unsigned MAX_LEN_DEF = 4096;
	localparam int unsigned HW = 30;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_BAD_RANGE = 2'd3;

	localparam logic [7:0] LETTER_A = 8'd97;
	localparam logic [7:0] LETTER_Z = 8'd122;

	localparam logic [HW-1:0] MOD0 = 30'd1000000009;
	localparam logic [HW-1:0] MOD1 = 30'd1000000007;
	localparam logic [HW-1:0] MOD2 = 30'd1000000013;
	localparam logic [HW-1:0] BINV0 = 30'd838709685;
	localparam logic [HW-1:0] BINV1 = 30'd129032259;
	localparam logic [HW-1:0] BINV2 = 30'd516129039;

	typedef logic [HW-1:0] hash_t;
	typedef logic [HW:0] mu_t;

	// Barrett reciprocals, floor(2^60 / p), one for each modulus.
	localparam mu_t MU0 = mu_t'(64'h1000_0000_0000_0000 / 64'(MOD0));
	localparam mu_t MU1 = mu_t'(64'h1000_0000_0000_0000 / 64'(MOD1));
	localparam mu_t MU2 = mu_t'(64'h1000_0000_0000_0000 / 64'(MOD2));

	function automatic hash_t add_mod(input hash_t a, input hash_t b, input hash_t p);
		logic [HW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p}) s = s - {1'b0, p};
		return s[HW-1:0];
	endfunction

	function automatic hash_t sub_mod(input hash_t a, input hash_t b, input hash_t p);
		logic [HW:0] s;
		s = {1'b0, a} + {1'b0, p} - {1'b0, b};
		if (s >= {1'b0, p}) s = s - {1'b0, p};
		return s[HW-1:0];
	endfunction

endpackage

// ===== rtl/tmsh_modmul.sv =====
// One modulus lane: 30x30 multiply into x_s1, then Barrett reduction through
// q_s2, r_s3 and the prod register. Done rises together with the result.
module tmsh_modmul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tmsh_pkg::hash_t     a,
	input  tmsh_pkg::hash_t     b,
	input  tmsh_pkg::hash_t     p,
	input  tmsh_pkg::mu_t       mu,
	output logic                done,
	output tmsh_pkg::hash_t     prod
);
	import tmsh_pkg::*;

	logic [2*HW-1:0] x_s1;
	logic [HW:0] q_s2;
	logic [31:0] x_s2, r_s3;
	logic [2*HW+1:0] qm;
	logic [31:0] qp, r1;
	logic v_s1, v_s2, v_s3;

	// The quotient estimate is short by at most two, so the remainder is
	// below 3p and fits in 32 bits.
	always_comb begin
		qm = (2*HW+2)'(x_s1[2*HW-1:HW-1]) * (2*HW+2)'(mu);
		qp = 32'(q_s2) * 32'(p);
		if (r_s3 >= {1'b0, p, 1'b0}) r1 = r_s3 - {1'b0, p, 1'b0};
		else if (r_s3 >= {2'b00, p}) r1 = r_s3 - {2'b00, p};
		else r1 = r_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= (2*HW)'(a) * (2*HW)'(b);
		q_s2 <= qm[2*HW+1:HW+1];
		x_s2 <= x_s1[31:0];
		r_s3 <= x_s2 - qp;
		prod <= r1[HW-1:0];
	end
endmodule

// ===== rtl/tmsh_lane.sv =====
// Memories and arithmetic for one modulus.
module tmsh_lane #(
	parameter int unsigned MAX_LEN = tmsh_pkg::MAX_LEN_DEF,
	parameter int unsigned AW = $clog2(MAX_LEN)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tmsh_pkg::hash_t   p,
	input  tmsh_pkg::mu_t     mu,
	input  tmsh_pkg::hash_t   binv,
	input  logic              clr,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  tmsh_pkg::hash_t   wr_pre,
	input  logic [AW-1:0]     inv_addr,
	output tmsh_pkg::hash_t   pre_rd,
	output tmsh_pkg::hash_t   inv_rd,
	output tmsh_pkg::hash_t   pow_now,
	input  logic              mul_start,
	input  tmsh_pkg::hash_t   mul_a,
	input  tmsh_pkg::hash_t   mul_b,
	output logic              mul_done,
	output tmsh_pkg::hash_t   mul_p,
	input  logic              step_pow
);
	import tmsh_pkg::*;

	hash_t pre_mem [MAX_LEN];
	hash_t inv_mem [MAX_LEN];
	hash_t pow_q, invn_q;
	hash_t pw31, ipw;
	logic pd, id;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pre_mem[wr_addr] <= wr_pre;
			inv_mem[wr_addr] <= invn_q;
		end
		if (rd_en) begin
			pre_rd <= pre_mem[rd_addr];
			inv_rd <= inv_mem[inv_addr];
		end
	end

	tmsh_modmul u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b), .p, .mu,
		.done(mul_done), .prod(mul_p));
	tmsh_modmul u_pow (.clk, .arst_n, .start(step_pow), .a(pow_q), .b(30'd31), .p, .mu,
		.done(pd), .prod(pw31));
	tmsh_modmul u_inv (.clk, .arst_n, .start(step_pow), .a(invn_q), .b(binv), .p, .mu,
		.done(id), .prod(ipw));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_q <= 30'd1;
			invn_q <= 30'd1;
		end else if (clr) begin
			pow_q <= 30'd1;
			invn_q <= 30'd1;
		end else begin
			if (pd) pow_q <= pw31;
			if (id) invn_q <= ipw;
		end
	end

	assign pow_now = pow_q;
endmodule

// ===== rtl/triple_modulus_substring_hash_core.sv =====
// Triple-modulus polynomial substring hash.
// Input channel s_axis: tuser carries kind (0 clear, 1 append, 2 query);
// tdata carries char_code, left and right. Output channel m_axis: tdata
// carries the three hashes, tuser the status code.
// One input transfer gives exactly one output transfer. A clear, a rejected
// item or kind 3 goes from S_IDLE straight to S_OUT, which raises
// m_axis_tvalid. An append or a valid query passes through two memory read
// states (S_RD1, S_RD2), S_MUL to start the modular multiply, S_WAIT while
// the pipelined Barrett multiplier works, with the output register loaded
// when it is done, and then S_OUT. Either way the next transfer can be taken
// only once the block is back in S_IDLE. The next powers of 31 and of its
// inverse are computed in parallel with an append.
// Only one item is in flight; s_axis_tready is low while it works.
// The result sits in an output register; a new item is taken when the
// result is taken or the register is empty, so a stalled receiver only
// holds the block. Reset empties the string (length 0, powers 1); the
// memories are not cleared since only written entries are ever used.
module triple_modulus_substring_hash_core #(
	parameter int unsigned MAX_LEN = tmsh_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // char_code[7:0], left[19:8], right[31:20]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // hash_first, hash_second, hash_third, 30 bits each
	output logic [1:0]  m_axis_tuser   // status[1:0]
);
	import tmsh_pkg::*;

	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned LW = $clog2(MAX_LEN + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] st_q;
	logic [LW-1:0] len_q;
	logic [1:0] kind_q;
	logic [4:0] let_q;
	logic [11:0] left_q, right_q;
	hash_t hi_q [3];
	hash_t res_q [3];
	logic [1:0] stat_q;
	logic ov_q;

	hash_t pv [3];
	mu_t muv [3];
	hash_t bv [3];
	hash_t pre_rd [3], inv_rd [3], pown [3], mp [3];
	logic md [3];
	logic rd_en, wr_en, clr, mstart, stepp;
	logic [AW-1:0] rd_addr, inv_addr, wr_addr;
	hash_t ma [3], mb [3], wpre [3];
	logic acc;
	logic q_ok;
	logic [7:0] cc;
	logic [11:0] li, ri;

	assign pv = '{MOD0, MOD1, MOD2};
	assign muv = '{MU0, MU1, MU2};
	assign bv = '{BINV0, BINV1, BINV2};
	assign cc = s_axis_tdata[7:0];
	assign li = s_axis_tdata[19:8];
	assign ri = s_axis_tdata[31:20];

	// A query range is valid when it is ordered and ends inside the string.
	assign q_ok = (li <= ri) && ({20'd0, ri} < 32'(len_q));

	assign s_axis_tready = (st_q == S_IDLE) && (!ov_q || m_axis_tready);
	assign acc = s_axis_tvalid && s_axis_tready;

	assign clr = acc && s_axis_tuser == KIND_CLEAR;
	assign wr_addr = len_q[AW-1:0];
	assign inv_addr = AW'(left_q);
	assign rd_en = (st_q == S_RD1) || (st_q == S_RD2);
	assign rd_addr = (st_q == S_RD1) ?
		((kind_q == KIND_APPEND) ? AW'(len_q - LW'(1)) : AW'(right_q)) :
		AW'(left_q - 12'd1);
	assign stepp = (st_q == S_MUL) && kind_q == KIND_APPEND;
	assign mstart = (st_q == S_MUL);
	assign wr_en = (st_q == S_WAIT) && md[0] && kind_q == KIND_APPEND;

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			if (kind_q == KIND_APPEND) begin
				ma[m] = {25'd0, let_q};
				mb[m] = pown[m];
			end else begin
				ma[m] = (left_q == 12'd0) ? hi_q[m] : sub_mod(hi_q[m], pre_rd[m], pv[m]);
				mb[m] = inv_rd[m];
			end
			wpre[m] = add_mod(hi_q[m], mp[m], pv[m]);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		tmsh_lane #(.MAX_LEN(MAX_LEN), .AW(AW)) u_lane (
			.clk, .arst_n, .p(pv[g]), .mu(muv[g]), .binv(bv[g]), .clr, .rd_en, .rd_addr,
			.wr_en, .wr_addr, .wr_pre(wpre[g]), .inv_addr, .pre_rd(pre_rd[g]),
			.inv_rd(inv_rd[g]), .pow_now(pown[g]),
			.mul_start(mstart), .mul_a(ma[g]), .mul_b(mb[g]), .mul_done(md[g]),
			.mul_p(mp[g]), .step_pow(stepp));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			len_q <= '0;
			ov_q <= 1'b0;
			kind_q <= KIND_CLEAR;
		end else begin
			if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (acc) begin
					kind_q <= s_axis_tuser;
					st_q <= S_OUT;
					if (s_axis_tuser == KIND_CLEAR) begin
						len_q <= '0;
					end else if (s_axis_tuser == KIND_APPEND) begin
						if (cc >= LETTER_A && cc <= LETTER_Z && len_q < LW'(MAX_LEN))
							st_q <= S_RD1;
					end else if (s_axis_tuser == KIND_QUERY) begin
						if (q_ok)
							st_q <= S_RD1;
					end
				end
				S_RD1: st_q <= S_RD2;
				S_RD2: st_q <= S_MUL;
				S_MUL: st_q <= S_WAIT;
				S_WAIT: if (md[0]) begin
					st_q <= S_OUT;
					if (kind_q == KIND_APPEND) len_q <= len_q + LW'(1);
				end
				S_OUT: begin
					st_q <= S_IDLE;
					ov_q <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			let_q <= 5'(cc - LETTER_A + 8'd1);
			left_q <= li;
			right_q <= ri;
			stat_q <= ST_OK;
			for (int m = 0; m < 3; m++) res_q[m] <= '0;
			if (s_axis_tuser == KIND_APPEND) begin
				if (cc < LETTER_A || cc > LETTER_Z) stat_q <= ST_BAD_CHAR;
				else if (len_q >= LW'(MAX_LEN)) stat_q <= ST_FULL;
			end else if (s_axis_tuser == KIND_QUERY) begin
				if (!q_ok)
					stat_q <= ST_BAD_RANGE;
			end
		end
		if (st_q == S_RD2) begin
			for (int m = 0; m < 3; m++)
				hi_q[m] <= (kind_q == KIND_APPEND && len_q == '0) ? '0 : pre_rd[m];
		end
		if (st_q == S_WAIT && md[0]) begin
			for (int m = 0; m < 3; m++)
				res_q[m] <= (kind_q == KIND_APPEND) ? wpre[m] : mp[m];
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {6'd0, res_q[2], res_q[1], res_q[0]};
	assign m_axis_tuser = stat_q;

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !s_axis_tready)
		else $error("input taken while busy");
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LEN))
		else $error("length overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !m_axis_tready) |=> ov_q && $stable(m_axis_tdata))
		else $error("result dropped");
	a_wr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> len_q < LW'(MAX_LEN))
		else $error("write past end");
endmodule

// ===== bench/triple_modulus_substring_hash_core_tb.sv =====
module triple_modulus_substring_hash_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmsh_pkg::*;

	// Kind 3 is not defined by the block; it must answer with zeros and status ok.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned STORE_DEPTH = MAX_LEN_DEF;
	// Length of the string built by the long string test.
	localparam int unsigned LONG_LEN = 300;
	// Cycles without any transfer before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 20000;
	// Quiet cycles after the last result so a late extra result still shows up.
	localparam int unsigned TAIL_CYCLES = 60;

	typedef struct {
		hash_t      first;
		hash_t      second;
		hash_t      third;
		logic [1:0] status;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // char_code[7:0], left[19:8], right[31:20]
	logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;       // hash_first[29:0], hash_second[59:30], hash_third[89:60]
	logic [1:0]  m_axis_tuser;       // status[1:0]

	triple_modulus_substring_hash_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Shadow copy of the string state, one column per modulus.
	hash_t       moduli [3];
	hash_t       base_inv [3];
	hash_t       prefix_sum [3][STORE_DEPTH];
	hash_t       inv_power [3][STORE_DEPTH];
	hash_t       power_cur [3];
	hash_t       inverse_cur [3];
	logic [12:0] str_len;

	digest_t     pending_digests [$];
	int unsigned error_count = 0;
	int unsigned send_gap_pct = 0;
	int unsigned recv_gap_pct = 0;
	int unsigned hold_off_cycles = 0;
	int unsigned quiet_cycles = 0;

	function automatic hash_t mul_mod(hash_t a, hash_t b, hash_t p);
		longint unsigned prod;
		prod = longint'(a) * longint'(b);
		return hash_t'(prod % longint'(p));
	endfunction

	function automatic void restart_string();
		for (int m = 0; m < 3; m++) begin
			power_cur[m] = 1;
			inverse_cur[m] = 1;
		end
		str_len = '0;
	endfunction

	// Applies one item to the shadow state and returns the result it must produce.
	function automatic digest_t hash_update(logic [1:0] kind, logic [7:0] code,
			logic [11:0] left, logic [11:0] right);
		digest_t d;
		hash_t h [3];
		hash_t prev, lo, diff, term;
		h = '{0, 0, 0};
		d.status = ST_OK;
		case (kind)
			KIND_CLEAR: restart_string();
			KIND_APPEND: begin
				if (code < LETTER_A || code > LETTER_Z) begin
					d.status = ST_BAD_CHAR;
				end else if (str_len >= STORE_DEPTH) begin
					d.status = ST_FULL;
				end else begin
					for (int m = 0; m < 3; m++) begin
						prev = (str_len > 0) ? prefix_sum[m][str_len - 1] : '0;
						term = mul_mod(hash_t'(code - LETTER_A + 1), power_cur[m], moduli[m]);
						h[m] = hash_t'((longint'(prev) + term) % moduli[m]);
						prefix_sum[m][str_len] = h[m];
						inv_power[m][str_len] = inverse_cur[m];
						power_cur[m] = mul_mod(power_cur[m], 30'd31, moduli[m]);
						inverse_cur[m] = mul_mod(inverse_cur[m], base_inv[m], moduli[m]);
					end
					str_len++;
				end
			end
			KIND_QUERY: begin
				if (left > right || right >= str_len) begin
					d.status = ST_BAD_RANGE;
				end else begin
					for (int m = 0; m < 3; m++) begin
						lo = (left > 0) ? prefix_sum[m][left - 1] : '0;
						diff = hash_t'((longint'(prefix_sum[m][right]) + moduli[m] - lo)
							% moduli[m]);
						h[m] = mul_mod(diff, inv_power[m][left], moduli[m]);
					end
				end
			end
			default: ;
		endcase
		d.first = h[0];
		d.second = h[1];
		d.third = h[2];
		return d;
	endfunction

	// Offers one item, possibly after a random gap, and records its result once
	// the transfer happens. Valid stays high when the next item follows at once.
	task automatic send_item(logic [1:0] kind, logic [7:0] code, logic [11:0] left,
			logic [11:0] right);
		if ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {right, left, code};
		do @(negedge clk); while (!s_axis_tready);
		pending_digests.push_back(hash_update(kind, code, left, right));
		@(posedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Lets every outstanding result drain, then waits TAIL_CYCLES of slack.
	task automatic wait_drained();
		while (pending_digests.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] any_letter();
		return LETTER_A + 8'($urandom_range(25));
	endfunction

	task automatic append_letter(logic [7:0] code);
		send_item(KIND_APPEND, code, 12'($urandom), 12'($urandom));
	endtask

	task automatic query_range(logic [11:0] left, logic [11:0] right);
		send_item(KIND_QUERY, 8'($urandom), left, right);
	endtask

	task automatic clear_string();
		send_item(KIND_CLEAR, 8'($urandom), 12'($urandom), 12'($urandom));
	endtask

	// Extremes of every field and the bad-character and bad-range rejections on a short string.
	task automatic test_directed();
		query_range(12'd0, 12'd0);          // query on an empty string
		append_letter(LETTER_A);
		append_letter(LETTER_Z);
		append_letter(8'd0);                // bytes outside the alphabet
		append_letter(8'd96);
		append_letter(8'd123);
		append_letter(8'd255);
		send_item(KIND_UNUSED, 8'hff, 12'hfff, 12'hfff);
		append_letter(8'd109);
		query_range(12'd0, 12'd0);
		query_range(12'd0, 12'd2);
		query_range(12'd1, 12'd2);
		query_range(12'd2, 12'd2);
		query_range(12'd2, 12'd1);          // left above right
		query_range(12'd0, 12'd3);          // right at the length
		query_range(12'hfff, 12'hfff);
		clear_string();
		query_range(12'd0, 12'd0);
		append_letter(LETTER_Z);
		query_range(12'd0, 12'd0);
		stop_sending();
		wait_drained();
	endtask

	// Builds a string of a few hundred letters and queries ranges across it.
	task automatic test_long_string();
		int unsigned r;
		clear_string();
		for (int i = 0; i < LONG_LEN; i++) append_letter(any_letter());
		append_letter(8'd64);
		query_range(12'd0, 12'(LONG_LEN - 1));
		query_range(12'(LONG_LEN - 1), 12'(LONG_LEN - 1));
		query_range(12'd0, 12'(LONG_LEN));  // right at the length
		query_range(12'hfff, 12'hfff);
		query_range(12'h800, 12'hffe);
		for (int i = 0; i < 40; i++) begin
			r = $urandom_range(LONG_LEN - 1);
			query_range(12'($urandom_range(r)), 12'(r));
		end
		clear_string();
		stop_sending();
		wait_drained();
	endtask

	// Mostly well-formed appends and queries on short strings, with some noise.
	task automatic test_random(int unsigned count, int unsigned s_pct, int unsigned r_pct);
		int unsigned pick, r;
		send_gap_pct = s_pct;
		recv_gap_pct = r_pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 3 || (str_len > 60 && pick < 10)) begin
				clear_string();
			end else if (pick < 48) begin
				append_letter(any_letter());
			end else if (pick < 88 && str_len > 0) begin
				r = $urandom_range(str_len - 1);
				query_range(12'($urandom_range(r)), 12'(r));
			end else if (pick < 92) begin
				append_letter(8'($urandom));
			end else if (pick < 96) begin
				query_range(12'($urandom), 12'($urandom));
			end else begin
				send_item(KIND_UNUSED, 8'($urandom), 12'($urandom), 12'($urandom));
			end
		end
		stop_sending();
		wait_drained();
	endtask

	// The receiver holds off while items keep coming, so the input must stall;
	// then the sender pauses until everything has come back.
	task automatic test_back_pressure();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_off_cycles = 400;
		clear_string();
		for (int i = 0; i < 12; i++) append_letter(any_letter());
		for (int i = 0; i < 8; i++) query_range(12'($urandom_range(3)), 12'd11);
		stop_sending();
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_off_cycles != 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Outputs are looked at mid-cycle, where they hold the values that the next
	// rising edge will see.
	always @(negedge clk) begin
		digest_t want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_digests.size() == 0) begin
					$error("result transfer with nothing outstanding");
					error_count++;
				end else begin
					want = pending_digests.pop_front();
					if (m_axis_tdata[29:0] !== want.first) begin
						$error("hash_first expected %0d got %0d", want.first,
							m_axis_tdata[29:0]);
						error_count++;
					end
					if (m_axis_tdata[59:30] !== want.second) begin
						$error("hash_second expected %0d got %0d", want.second,
							m_axis_tdata[59:30]);
						error_count++;
					end
					if (m_axis_tdata[89:60] !== want.third) begin
						$error("hash_third expected %0d got %0d", want.third,
							m_axis_tdata[89:60]);
						error_count++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status expected %0d got %0d", want.status, m_axis_tuser);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		moduli = '{MOD0, MOD1, MOD2};
		base_inv = '{BINV0, BINV1, BINV2};
		restart_string();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_long_string();
		test_random(460, 31, 75);
		test_random(460, 75, 31);
		test_back_pressure();
		test_random(460, 0, 0);

		if (pending_digests.size() != 0) begin
			$error("%0d results never arrived", pending_digests.size());
			error_count++;
		end
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tmsh_pkg.sv
rtl/tmsh_modmul.sv
rtl/tmsh_lane.sv
rtl/triple_modulus_substring_hash_core.sv
bench/triple_modulus_substring_hash_core_tb.sv
